// ----- hdl/ppc_pkg.sv -----
// Package for the palette pixel converter: constants, register codes and
// the item structs of the request and response channels. No dependencies.

package ppc_pkg;

   // Size limits of the converter.
   localparam int MAX_WIDTH       = 2048;
   localparam int MAX_HEIGHT      = 2048;
   localparam int PALETTE_ENTRIES = 256;

   // Field widths fixed by the item formats.
   localparam int SIZE_W    = 12;
   localparam int KEY_W     = 24;
   localparam int SLOT_W    = 8;
   localparam int PIXEL_W   = 32;
   localparam int DEST_W    = 22;
   localparam int CSR_IDX_W = 3;
   localparam int CSR_DATA_W = 24;

   // Derived widths.
   localparam int COL_W  = $clog2(MAX_WIDTH);
   localparam int ROW_W  = $clog2(MAX_HEIGHT);
   localparam int PAL_AW = $clog2(PALETTE_ENTRIES);

   // Operation codes carried in the request op field.
   localparam logic OP_PALETTE = 1'b0;
   localparam logic OP_PIXEL   = 1'b1;

   // Configuration register indexes.
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_OUTPUT_MODE  = 3'd0,
      CSR_SOURCE_32BIT = 3'd1,
      CSR_ALPHA_ENABLE = 3'd2,
      CSR_KEY_ENABLE   = 3'd3,
      CSR_COLOR_KEY    = 3'd4,
      CSR_FLIP_ROWS    = 3'd5,
      CSR_IMAGE_WIDTH  = 3'd6,
      CSR_IMAGE_HEIGHT = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic               op;
      logic [SLOT_W-1:0]  palette_slot;
      logic [PIXEL_W-1:0] pixel_value;
   } req_payload_type;

   typedef struct packed {
      logic [DEST_W-1:0] dest_index;
      logic [7:0]        red;
      logic [7:0]        green;
      logic [7:0]        blue;
      logic [7:0]        alpha_byte;
      logic              has_alpha;
      logic [15:0]       word_5551;
      logic              last_pixel;
   } rsp_payload_type;

endpackage

// ----- hdl/palette_pixel_converter_unit.sv -----
// Top level of the palette pixel converter: palette memory, raster counters,
// colour lookup and RGB888 / RGBA8888 / RGB5551 packing. Depends on ppc_pkg.

// Channel  | Direction | Handshake          | Item
// ---------+-----------+--------------------+-----------------------------------
// req      | in        | req_valid/req_stall | palette write or pixel
// rsp      | out       | rsp_valid/rsp_stall | one converted pixel per pixel item
// csr      | in        | csr_we             | register index and write data
//
// An item is accepted in every cycle while the output side keeps up. A pixel
// item passes stage one, whose accept edge reads the palette memory and latches
// the raster position, then the response register, which takes the packed
// colour. Palette writes are done at their accept edge and give no result.
// Reset is synchronous; it clears the valid flags and counters and resets the
// configuration registers; data registers and the palette memory are not
// cleared, and req_stall is held high throughout. A stall on rsp holds both
// stages and reaches req_stall in the same cycle only when both are occupied.

module palette_pixel_converter_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ppc_pkg::req_payload_type         req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ppc_pkg::rsp_payload_type         rsp_payload,
   input  logic                             csr_we,
   input  logic [ppc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ppc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   import ppc_pkg::*;

   localparam int PROD_W = ROW_W + SIZE_W;

   // Configuration registers.
   logic              output_mode_ff;
   logic              source_32bit_ff;
   logic              alpha_enable_ff;
   logic              key_enable_ff;
   logic [KEY_W-1:0]  color_key_ff;
   logic              flip_rows_ff;
   logic [SIZE_W-1:0] image_width_ff;
   logic [SIZE_W-1:0] image_height_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         output_mode_ff  <= 1'b0;
         source_32bit_ff <= 1'b0;
         alpha_enable_ff <= 1'b0;
         key_enable_ff   <= 1'b0;
         color_key_ff    <= '0;
         flip_rows_ff    <= 1'b1;
         image_width_ff  <= SIZE_W'(1);
         image_height_ff <= SIZE_W'(1);
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_OUTPUT_MODE:  output_mode_ff  <= csr_wdata[0];
            CSR_SOURCE_32BIT: source_32bit_ff <= csr_wdata[0];
            CSR_ALPHA_ENABLE: alpha_enable_ff <= csr_wdata[0];
            CSR_KEY_ENABLE:   key_enable_ff   <= csr_wdata[0];
            CSR_COLOR_KEY:    color_key_ff    <= csr_wdata[KEY_W-1:0];
            CSR_FLIP_ROWS:    flip_rows_ff    <= csr_wdata[0];
            CSR_IMAGE_WIDTH:  image_width_ff  <= csr_wdata[SIZE_W-1:0];
            CSR_IMAGE_HEIGHT: image_height_ff <= csr_wdata[SIZE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Effective image size: zero is taken as one, oversize as the maximum.
   logic [SIZE_W-1:0] width_eff;
   logic [SIZE_W-1:0] height_eff;

   always_comb begin
      if (image_width_ff == '0) begin
         width_eff = SIZE_W'(1);
      end else if (image_width_ff > SIZE_W'(MAX_WIDTH)) begin
         width_eff = SIZE_W'(MAX_WIDTH);
      end else begin
         width_eff = image_width_ff;
      end
      if (image_height_ff == '0) begin
         height_eff = SIZE_W'(1);
      end else if (image_height_ff > SIZE_W'(MAX_HEIGHT)) begin
         height_eff = SIZE_W'(MAX_HEIGHT);
      end else begin
         height_eff = image_height_ff;
      end
   end

   // Pipeline flow control. The response register advances when it is
   // empty or being taken; stage one loads when it is empty or can pass on.
   logic s1_valid_ff;
   logic s1_valid_in;
   logic rsp_valid_ff;
   logic advance;
   logic s1_load;
   logic req_accept;
   logic pal_write;
   logic pix_accept;

   assign advance    = !rsp_valid_ff || !rsp_stall;
   assign s1_load    = !s1_valid_ff || advance;
   assign req_stall  = reset || !s1_load;
   assign req_accept = req_valid && !req_stall;
   assign pal_write  = req_accept && (req_payload.op == OP_PALETTE);
   assign pix_accept = req_accept && (req_payload.op == OP_PIXEL);

   // Palette memory: BGR entries, B in the low byte.
   logic [KEY_W-1:0] palette_mem [PALETTE_ENTRIES];
   logic [KEY_W-1:0] pal_rdata_ff;

   always_ff @(posedge clock) begin
      if (pal_write) begin
         palette_mem[req_payload.palette_slot[PAL_AW-1:0]] <= req_payload.pixel_value[KEY_W-1:0];
      end
      if (pix_accept) begin
         pal_rdata_ff <= palette_mem[req_payload.pixel_value[PAL_AW-1:0]];
      end
   end

   // Raster counters. A counter left beyond a shrunk size restarts at zero.
   logic [COL_W-1:0] col_ff;
   logic [COL_W-1:0] col_in;
   logic [ROW_W-1:0] row_ff;
   logic [ROW_W-1:0] row_in;
   logic [COL_W-1:0] col_cur;
   logic [ROW_W-1:0] row_cur;
   logic             col_end;
   logic             row_end;
   logic             bottom_up;
   logic [ROW_W-1:0] dest_row;

   always_comb begin
      if ({{(SIZE_W-COL_W){1'b0}}, col_ff} >= width_eff) begin
         col_cur = '0;
      end else begin
         col_cur = col_ff;
      end
      if ({{(SIZE_W-ROW_W){1'b0}}, row_ff} >= height_eff) begin
         row_cur = '0;
      end else begin
         row_cur = row_ff;
      end
      col_end = ({{(SIZE_W-COL_W){1'b0}}, col_cur} == width_eff - SIZE_W'(1));
      row_end = ({{(SIZE_W-ROW_W){1'b0}}, row_cur} == height_eff - SIZE_W'(1));
      col_in  = col_ff;
      row_in  = row_ff;
      if (pix_accept) begin
         if (col_end) begin
            col_in = '0;
            row_in = row_end ? '0 : row_cur + ROW_W'(1);
         end else begin
            col_in = col_cur + COL_W'(1);
            row_in = row_cur;
         end
      end
      // Byte output and true-colour sources are always stored bottom-up.
      bottom_up = source_32bit_ff || !output_mode_ff || flip_rows_ff;
      if (bottom_up) begin
         dest_row = ROW_W'(height_eff - SIZE_W'(1) - {{(SIZE_W-ROW_W){1'b0}}, row_cur});
      end else begin
         dest_row = row_cur;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
      end else begin
         col_ff <= col_in;
         row_ff <= row_in;
      end
   end

   // Stage one: raster position and the source pixel, alongside the palette
   // read data.
   logic [COL_W-1:0] s1_col_ff;
   logic [ROW_W-1:0] s1_row_ff;
   logic             s1_last_ff;
   logic [KEY_W-1:0] s1_pixel_ff;

   assign s1_valid_in = s1_load ? pix_accept : s1_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
      if (pix_accept) begin
         s1_col_ff   <= col_cur;
         s1_row_ff   <= dest_row;
         s1_last_ff  <= col_end && row_end;
         s1_pixel_ff <= req_payload.pixel_value[KEY_W-1:0];
      end
   end

   // Stage two: colour selection, transparency, packing and the address.
   logic [KEY_W-1:0]  colour;
   logic              opaque;
   logic              with_alpha;
   logic [PROD_W-1:0] dest_sum;
   rsp_payload_type   rsp_in;

   always_comb begin
      // An 8-bit source keeps its palette index in the low byte.
      colour = source_32bit_ff ? s1_pixel_ff : pal_rdata_ff;
      if (source_32bit_ff) begin
         opaque = 1'b1;
      end else begin
         opaque = (s1_pixel_ff[PAL_AW-1:0] != '0) &&
                  !(key_enable_ff && (pal_rdata_ff == color_key_ff));
      end
      with_alpha = alpha_enable_ff || key_enable_ff;
      dest_sum = PROD_W'({{SIZE_W{1'b0}}, s1_row_ff} * {{ROW_W{1'b0}}, width_eff}) +
                 PROD_W'(s1_col_ff);
      rsp_in            = '0;
      rsp_in.dest_index = dest_sum[DEST_W-1:0];
      rsp_in.last_pixel = s1_last_ff;
      if (output_mode_ff) begin
         rsp_in.word_5551 = {!source_32bit_ff && opaque, colour[7:3], colour[15:11],
                             colour[23:19]};
      end else begin
         rsp_in.red        = colour[23:16];
         rsp_in.green      = colour[15:8];
         rsp_in.blue       = colour[7:0];
         rsp_in.has_alpha  = with_alpha;
         rsp_in.alpha_byte = (with_alpha && opaque) ? 8'hFF : 8'h00;
      end
   end

   rsp_payload_type rsp_payload_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= s1_valid_ff;
      end
      if (advance && s1_valid_ff) begin
         rsp_payload_ff <= rsp_in;
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // A palette write leaves stage one empty behind it.
   a_palette_no_result : assert property (@(posedge clock) disable iff (reset)
      pal_write |=> !s1_valid_ff)
      else $error("palette write produced a pending pixel");

   // The final pixel of an image returns both counters to the origin.
   a_last_rewinds : assert property (@(posedge clock) disable iff (reset)
      (pix_accept && col_end && row_end) |=> (col_ff == '0 && row_ff == '0))
      else $error("raster counters not rewound after last pixel");

   // Outside reset, input back-pressure only arises with both stages full and the output held.
   a_stall_cause : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (s1_valid_ff && rsp_valid_ff && rsp_stall))
      else $error("request stalled without a full pipeline");

endmodule
